FILE: design/lct_pkg.sv
// Package for the listener connection tracker.
// Holds payload structs, codes and the queue entry type; no dependencies.
package lct_pkg;

    typedef enum logic [2:0] {
        M_OPEN = 3'd0, M_CLOSE = 3'd1, M_LST_OPENED = 3'd2, M_NEW_CONN = 3'd3,
        M_LST_FAIL = 3'd4, M_CH_CREATED = 3'd5, M_CH_DISC = 3'd6, M_UNUSED = 3'd7
    } t_mode;

    localparam logic [2:0] K_CREATE_SERVER  = 3'd0;
    localparam logic [2:0] K_SOCKET_CLOSE   = 3'd1;
    localparam logic [2:0] K_CHANNEL_CLOSE  = 3'd2;
    localparam logic [2:0] K_CHANNEL_CREATE = 3'd3;
    localparam logic [2:0] K_EP_CLOSED      = 3'd4;

    localparam logic [1:0] ST_CLOSED  = 2'd0;
    localparam logic [1:0] ST_OPENING = 2'd1;
    localparam logic [1:0] ST_OPENED  = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_CLOSED  = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  endpoint;
        logic [15:0] aux_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [15:0] out_target;
        logic [3:0]  out_endpoint;
        logic [1:0]  out_status;
        logic        out_last;
    } t_out;

    // Classified command passed from front to back.
    typedef struct packed {
        t_mode       mode;
        logic [3:0]  endpoint;
        logic [15:0] aux_index;
        logic        valid_ep;
        logic        configured;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_EMIT, S_SOCK, S_FINAL
    } t_state;

endpackage

FILE: design/lct_front.sv
// Front part: accepts input beats, classifies the endpoint and queues commands.
// Depends on lct_pkg.
module lct_front #(
    parameter int NUM_ENDPOINTS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lct_pkg::t_in  i_data,
    input  logic [7:0]    i_mask,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output lct_pkg::t_cmd o_cmd
);
    lct_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    lct_pkg::t_cmd n_cmd;
    logic          push, pop;

    always_comb begin
        n_cmd.mode       = lct_pkg::t_mode'(i_data.mode);
        n_cmd.endpoint   = i_data.endpoint;
        n_cmd.aux_index  = i_data.aux_index;
        n_cmd.valid_ep   = (i_data.endpoint >= 4'd1) &&
                           ({1'b0, i_data.endpoint} <= 5'(NUM_ENDPOINTS));
        n_cmd.configured = (i_data.endpoint >= 4'd1) && (i_data.endpoint <= 4'd8) &&
                           i_mask[3'(i_data.endpoint - 4'd1)];
    end

    assign o_ready     = r_cnt != 2'd2;
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end
endmodule

FILE: design/lct_back.sv
// Back part: listener state, slot tables and the result sequencer, plus the
// generic RAM that holds the slot channels. Depends on lct_pkg.
module lct_back #(
    parameter int NUM_ENDPOINTS      = 8,
    parameter int SLOTS_PER_LISTENER = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  lct_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output lct_pkg::t_out o_data
);
    localparam int LW = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam int SW = (SLOTS_PER_LISTENER > 1) ? $clog2(SLOTS_PER_LISTENER) : 1;
    localparam int CW = $clog2(SLOTS_PER_LISTENER + 1);
    localparam int DEPTH = 1 << (LW + SW);

    logic [1:0]  r_lmode [NUM_ENDPOINTS];
    logic [15:0] r_lsock [NUM_ENDPOINTS];
    logic [SW-1:0] r_last [NUM_ENDPOINTS];
    logic [SLOTS_PER_LISTENER-1:0] r_used [NUM_ENDPOINTS];

    lct_pkg::t_state r_state, n_state;
    lct_pkg::t_cmd   r_cmd;
    logic [LW-1:0]   li;
    logic [SW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_n, n_n;
    logic            r_ovalid, n_ovalid;
    lct_pkg::t_out   r_out, n_out;
    logic            n_take;
    logic [1:0]      lm;
    logic            out_free;
    logic [SW-1:0]   nxt_idx;
    logic [15:0]     chan_rdata;
    logic            chan_we;

    assign li       = LW'(r_cmd.endpoint - 4'd1);
    assign lm       = r_cmd.valid_ep ? r_lmode[li] : lct_pkg::ST_CLOSED;
    assign out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_data   = r_out;
    assign o_cmd_ready = r_state == lct_pkg::S_IDLE;
    assign nxt_idx  = (32'(r_idx) == SLOTS_PER_LISTENER - 1) ? '0 : r_idx + SW'(1);
    assign chan_we  = r_state == lct_pkg::S_SCAN && r_cmd.mode == lct_pkg::M_CH_CREATED &&
                      !r_used[li][r_idx];

    // The read address follows the next slot index, so the data matches r_idx.
    lct_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_chan_ram (
        .i_clk, .i_we(chan_we), .i_waddr({li, r_idx}), .i_wdata(r_cmd.aux_index),
        .i_raddr({li, n_idx}), .o_rdata(chan_rdata)
    );

    function automatic lct_pkg::t_out mk(logic [2:0] k, logic [15:0] t, logic [3:0] e,
                                         logic [1:0] s, logic l);
        lct_pkg::t_out o;
        o.out_kind = k; o.out_target = t; o.out_endpoint = e;
        o.out_status = s; o.out_last = l;
        return o;
    endfunction

    // Close of a configured endpoint goes through the slot walk when opened.
    logic do_close, walk;
    assign do_close = (r_cmd.mode == lct_pkg::M_CLOSE || r_cmd.mode == lct_pkg::M_LST_FAIL)
                      && r_cmd.configured && r_cmd.valid_ep;
    assign walk = do_close && lm == lct_pkg::ST_OPENED;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_n      = r_n;
        n_take   = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;
        unique case (r_state)
            lct_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_take  = 1'b1;
                    n_state = lct_pkg::S_DECIDE;
                end
            end
            lct_pkg::S_DECIDE: begin
                n_idx = '0;
                n_n   = '0;
                if (out_free) begin
                    n_state = lct_pkg::S_IDLE;
                    unique case (r_cmd.mode) inside
                        lct_pkg::M_OPEN: begin
                            if (r_cmd.configured && r_cmd.valid_ep && lm == lct_pkg::ST_CLOSED) begin
                                n_ovalid = 1'b1;
                                n_out = mk(lct_pkg::K_CREATE_SERVER, 16'd0, r_cmd.endpoint,
                                           lct_pkg::STS_OK, 1'b1);
                            end
                        end
                        lct_pkg::M_CLOSE, lct_pkg::M_LST_FAIL: begin
                            if (walk) begin
                                n_state = lct_pkg::S_EMIT;
                            end else begin
                                n_state = lct_pkg::S_FINAL;
                            end
                        end
                        lct_pkg::M_LST_OPENED: begin
                            if (!(r_cmd.valid_ep && lm == lct_pkg::ST_OPENING)) begin
                                n_ovalid = 1'b1;
                                n_out = mk(lct_pkg::K_SOCKET_CLOSE, r_cmd.aux_index, 4'd0,
                                           lct_pkg::STS_OK, 1'b1);
                            end
                        end
                        lct_pkg::M_NEW_CONN: begin
                            n_ovalid = 1'b1;
                            if (r_cmd.valid_ep && lm == lct_pkg::ST_OPENED) begin
                                n_out = mk(lct_pkg::K_CHANNEL_CREATE, r_cmd.aux_index,
                                           r_cmd.endpoint, lct_pkg::STS_OK, 1'b1);
                            end else begin
                                n_out = mk(lct_pkg::K_SOCKET_CLOSE, r_cmd.aux_index, 4'd0,
                                           lct_pkg::STS_OK, 1'b1);
                            end
                        end
                        lct_pkg::M_CH_CREATED: begin
                            if (r_cmd.valid_ep && lm == lct_pkg::ST_OPENED) begin
                                n_idx   = (32'(r_last[li]) == SLOTS_PER_LISTENER - 1) ? '0
                                          : r_last[li] + SW'(1);
                                n_state = lct_pkg::S_SCAN;
                            end else begin
                                n_ovalid = 1'b1;
                                n_out = mk(lct_pkg::K_CHANNEL_CLOSE, r_cmd.aux_index,
                                           r_cmd.endpoint, lct_pkg::STS_OK, 1'b1);
                            end
                        end
                        lct_pkg::M_CH_DISC: begin
                            if (r_cmd.valid_ep && lm == lct_pkg::ST_OPENED) begin
                                n_state = lct_pkg::S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lct_pkg::S_SCAN: begin
                // One slot per cycle for the free-slot and the channel search, unless a stalled output holds it.
                n_idx = nxt_idx;
                n_n   = r_n + CW'(1);
                if (r_cmd.mode == lct_pkg::M_CH_CREATED) begin
                    if (!r_used[li][r_idx]) begin
                        n_state = lct_pkg::S_IDLE;
                    end else if (32'(r_n) == SLOTS_PER_LISTENER - 1) begin
                        if (out_free) begin
                            n_ovalid = 1'b1;
                            n_out = mk(lct_pkg::K_CHANNEL_CLOSE, r_cmd.aux_index,
                                       r_cmd.endpoint, lct_pkg::STS_OK, 1'b1);
                            n_state = lct_pkg::S_IDLE;
                        end else begin
                            n_idx = r_idx;
                            n_n   = r_n;
                        end
                    end
                end else begin
                    if ((r_used[li][r_idx] && chan_rdata == r_cmd.aux_index) ||
                        32'(r_n) == SLOTS_PER_LISTENER - 1) begin
                        n_state = lct_pkg::S_IDLE;
                    end
                end
            end
            lct_pkg::S_EMIT: begin
                if (!r_used[li][r_idx]) begin
                    n_idx = nxt_idx;
                    n_n   = r_n + CW'(1);
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = mk(lct_pkg::K_CHANNEL_CLOSE, chan_rdata, r_cmd.endpoint,
                               lct_pkg::STS_OK, 1'b0);
                    n_idx = nxt_idx;
                    n_n   = r_n + CW'(1);
                end
                if (32'(n_n) == SLOTS_PER_LISTENER) begin
                    n_state = lct_pkg::S_SOCK;
                end
            end
            lct_pkg::S_SOCK: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = mk(lct_pkg::K_SOCKET_CLOSE, r_lsock[li], 4'd0,
                               lct_pkg::STS_OK, 1'b0);
                    n_state = lct_pkg::S_FINAL;
                end
            end
            lct_pkg::S_FINAL: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = mk(lct_pkg::K_EP_CLOSED, 16'd0, r_cmd.endpoint,
                               (r_cmd.mode == lct_pkg::M_LST_FAIL) ? lct_pkg::STS_CLOSED :
                               (r_cmd.configured && !r_cmd.valid_ep) ? lct_pkg::STS_INVALID :
                               lct_pkg::STS_OK, 1'b1);
                    n_state = lct_pkg::S_IDLE;
                end
            end
            default: n_state = lct_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lct_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            for (int e = 0; e < NUM_ENDPOINTS; e++) begin
                r_lmode[e] <= lct_pkg::ST_CLOSED;
                r_lsock[e] <= '0;
                r_last[e]  <= '0;
                r_used[e]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (r_state == lct_pkg::S_DECIDE && out_free) begin
                if (r_cmd.mode == lct_pkg::M_OPEN && r_cmd.configured && r_cmd.valid_ep &&
                    lm == lct_pkg::ST_CLOSED) begin
                    r_lmode[li] <= lct_pkg::ST_OPENING;
                end
                if (r_cmd.mode == lct_pkg::M_LST_OPENED && r_cmd.valid_ep &&
                    lm == lct_pkg::ST_OPENING) begin
                    r_lmode[li] <= lct_pkg::ST_OPENED;
                    r_lsock[li] <= r_cmd.aux_index;
                end
                if (do_close && lm == lct_pkg::ST_OPENING) begin
                    r_lmode[li] <= lct_pkg::ST_CLOSED;
                    r_lsock[li] <= '0;
                    r_last[li]  <= '0;
                    r_used[li]  <= '0;
                end
            end
            if (chan_we) begin
                r_used[li][r_idx] <= 1'b1;
                r_last[li]        <= r_idx;
            end
            if (r_state == lct_pkg::S_SCAN && r_cmd.mode == lct_pkg::M_CH_DISC &&
                r_used[li][r_idx] && chan_rdata == r_cmd.aux_index) begin
                r_used[li][r_idx] <= 1'b0;
            end
            if (r_state == lct_pkg::S_SOCK && out_free) begin
                r_lmode[li] <= lct_pkg::ST_CLOSED;
                r_lsock[li] <= '0;
                r_last[li]  <= '0;
                r_used[li]  <= '0;
            end
        end
        if (n_take) begin
            r_cmd <= i_cmd;
        end
        r_idx <= n_idx;
        r_n   <= n_n;
        r_out <= n_out;
    end
endmodule

// Generic RAM with one write port and one registered read port.
module lct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/listener_connection_tracker.sv
// Top level of the listener connection tracker.
// Instantiates lct_front and lct_back; uses lct_pkg.
//
// Each input beat is queued by the front part (two entries) and executed by the back
// part one event at a time. A channel created or disconnected event scans the slot
// table one slot per cycle, held only when a full free-slot search meets a stalled output,
// and a close of an opened listener walks every slot once, emitting one channel close
// per used slot, then a socket close and an endpoint closed beat.
module listener_connection_tracker #(
    parameter int NUM_ENDPOINTS      = 8,
    parameter int SLOTS_PER_LISTENER = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lct_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output lct_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data
);
    logic [7:0]    r_mask;
    logic          cmd_valid, cmd_ready;
    lct_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_data;
        end
    end

    lct_front #(.NUM_ENDPOINTS(NUM_ENDPOINTS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .i_mask(r_mask),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    lct_back #(.NUM_ENDPOINTS(NUM_ENDPOINTS), .SLOTS_PER_LISTENER(SLOTS_PER_LISTENER)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_data
    );
endmodule

FILE: design/lct_checker.sv
// Port-level checker for the listener connection tracker, with its bind.
// Depends on lct_pkg.
module lct_port_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_ready,
    input lct_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.out_kind <= lct_pkg::K_EP_CLOSED)
        else $error("bad result kind");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_kind != lct_pkg::K_EP_CLOSED |-> o_data.out_status == 2'd0)
        else $error("status on non-close result");
    a_sock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_kind == lct_pkg::K_SOCKET_CLOSE |-> o_data.out_endpoint == 4'd0)
        else $error("socket close carries endpoint");
endmodule

bind listener_connection_tracker lct_port_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);
